// ===== src/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants for the 3x3 matrix inverse core
// element format, internal widths, cofactor index tables, queue entry type
// ----------------------------------------------------------------------------
`default_nettype none
package m3i_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PW  = 2 * ELEM_WIDTH;       // 2x2 product
  localparam int MW  = PW + 2;               // minor / adjugate entry
  localparam int PLW = MW / 2;               // low split of an adjugate entry
  localparam int PHW = MW - PLW;             // high split
  localparam int DW  = ELEM_WIDTH + MW;      // determinant
  localparam int SH  = 2 * FRAC_BITS + 1;    // numerator scale
  localparam int NW  = MW + SH + 1;          // divider numerator / divisor
  localparam int QW  = ELEM_WIDTH + 1;       // quotient bits kept
  localparam int RW  = NW + QW;              // width of shifted divisor
  localparam int NL  = 9;                    // matrix elements
  localparam int QD  = 4;                    // queue depth
  localparam int QAW = $clog2(QD);
  localparam int FST = 7;                    // front pipeline stages

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [MW-1:0]         adj_t;
  typedef logic signed [DW-1:0]         det_t;

  // minor k = a[P]*a[S] - a[Q]*a[R], flat index row*3+col
  localparam int MI_P [NL] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int MI_Q [NL] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
  localparam int MI_R [NL] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
  localparam int MI_S [NL] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam logic [NL-1:0] ADJ_NEG = 9'b010101010;

  typedef struct packed {
    logic                   zero;
    logic [NL-1:0]          neg;
    logic [NW-1:0]          den2;
    logic [NL-1:0][NW-1:0]  num;
  } q_entry_t;

endpackage
`default_nettype wire

// ===== src/m3i_req_if.sv =====
// ----------------------------------------------------------------------------
// m3i_req_if: request channel carrying one input matrix
// valid/ready handshake with nine signed elements
// ----------------------------------------------------------------------------
`default_nettype none
interface m3i_req_if;
  import m3i_pkg::*;
  logic  valid;
  logic  ready;
  elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                 input ready);
  modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
               output ready);
endinterface
`default_nettype wire

// ===== src/m3i_resp_if.sv =====
// ----------------------------------------------------------------------------
// m3i_resp_if: response channel carrying one inverse matrix
// valid/ready handshake with nine signed elements and two flags
// ----------------------------------------------------------------------------
`default_nettype none
interface m3i_resp_if;
  import m3i_pkg::*;
  logic  valid;
  logic  ready;
  elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic  singular;
  logic  saturated;
  modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                 singular, saturated, input ready);
  modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
               singular, saturated, output ready);
endinterface
`default_nettype wire

// ===== src/m3i_front.sv =====
// ----------------------------------------------------------------------------
// m3i_front: adjugate and determinant pipeline
// computes minors, determinant, magnitudes and signs, builds divider operands
// ----------------------------------------------------------------------------
`default_nettype none
module m3i_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  m3i_pkg::elem_t    a [m3i_pkg::NL],
  output logic              out_valid,
  input  logic              out_ready,
  output m3i_pkg::q_entry_t out_entry
);
  import m3i_pkg::*;

  logic [FST:1] v;
  logic         en;

  prod_t ps1 [NL];
  prod_t qr1 [NL];
  adj_t  adj2 [NL];
  adj_t  adj3 [NL];
  adj_t  adj4 [NL];
  adj_t  adj5 [NL];
  elem_t r0_1 [3];
  elem_t r0_2 [3];
  logic signed [ELEM_WIDTH+PHW-1:0]   ph3 [3];
  logic signed [ELEM_WIDTH+PLW:0]     pl3 [3];
  det_t  t4 [3];
  det_t  det5;
  logic            zero6;
  logic            dneg6;
  logic [DW-1:0]   absd6;
  logic [NL-1:0]   mneg6;
  logic [MW-1:0]   absm6 [NL];
  q_entry_t        ent7;

  assign en        = !v[FST] || out_ready;
  assign in_ready  = en;
  assign out_valid = v[FST];
  assign out_entry = ent7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[FST-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        r0_1[j] <= a[j];
        r0_2[j] <= r0_1[j];
      end
      det5  <= t4[0] + t4[1] + t4[2];
      zero6 <= (det5 == '0);
      dneg6 <= det5[DW-1];
      absd6 <= det5[DW-1] ? DW'(-det5) : DW'(det5);
      ent7.zero <= zero6;
      ent7.den2 <= NW'(absd6) << 1;
    end
  end

  for (genvar k = 0; k < NL; k++) begin : g_minor
    always_ff @(posedge clk) begin
      if (en) begin
        ps1[k]  <= a[MI_P[k]] * a[MI_S[k]];
        qr1[k]  <= a[MI_Q[k]] * a[MI_R[k]];
        adj2[k] <= ADJ_NEG[k] ? adj_t'(qr1[k]) - adj_t'(ps1[k])
                              : adj_t'(ps1[k]) - adj_t'(qr1[k]);
        adj3[k] <= adj2[k];
        adj4[k] <= adj3[k];
        adj5[k] <= adj4[k];
        mneg6[k] <= adj5[k][MW-1];
        absm6[k] <= adj5[k][MW-1] ? MW'(-adj5[k]) : MW'(adj5[k]);
        ent7.neg[k] <= mneg6[k] ^ dneg6;
        ent7.num[k] <= (NW'(absm6[k]) << SH) + NW'(absd6);
      end
    end
  end

  // determinant terms: a0j times cofactor, split into two narrow products
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (en) begin
        ph3[j] <= r0_2[j] * $signed(adj2[3*j][MW-1:PLW]);
        pl3[j] <= r0_2[j] * $signed({1'b0, adj2[3*j][PLW-1:0]});
        t4[j]  <= (det_t'(ph3[j]) <<< PLW) + det_t'(pl3[j]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/m3i_queue.sv =====
// ----------------------------------------------------------------------------
// m3i_queue: short fifo between front and divider
// first-word fall-through, full/empty from an occupancy count
// ----------------------------------------------------------------------------
`default_nettype none
module m3i_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  m3i_pkg::q_entry_t in_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output m3i_pkg::q_entry_t out_entry
);
  import m3i_pkg::*;

  q_entry_t       mem [QD];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  logic           pop;

  assign in_ready  = (count != (QAW+1)'(QD));
  assign out_valid = (count != '0);
  assign out_entry = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_entry;
  end

endmodule
`default_nettype wire

// ===== src/m3i_back.sv =====
// ----------------------------------------------------------------------------
// m3i_back: pipelined restoring divider, rounding and saturation
// nine lanes, one quotient bit per stage, result register at the end
// ----------------------------------------------------------------------------
`default_nettype none
module m3i_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  m3i_pkg::q_entry_t in_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output m3i_pkg::elem_t    res [m3i_pkg::NL],
  output logic              singular,
  output logic              saturated
);
  import m3i_pkg::*;

  localparam logic [QW-1:0] HALF = QW'(1) << (ELEM_WIDTH - 1);
  localparam elem_t MAXV = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam elem_t MINV = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  logic [QW+1:0]  vb;
  logic           en;
  logic [NW-1:0]  rem [QW+1][NL];
  logic [QW-1:0]  quo [QW+1][NL];
  logic [NL-1:0]  big [QW+1];
  logic [NL-1:0]  ng  [QW+1];
  logic           zr  [QW+1];
  logic [NW-1:0]  dv  [QW+1];
  elem_t          fval [NL];
  logic [NL-1:0]  fsat;

  assign en        = !vb[QW+1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vb[QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[QW:0], in_valid};
    end
  end

  // stage 0: load operands, flag quotients too large for the kept bits
  always_ff @(posedge clk) begin
    if (en) begin
      ng[0] <= in_entry.neg;
      zr[0] <= in_entry.zero;
      dv[0] <= in_entry.den2;
      for (int k = 0; k < NL; k++) begin
        rem[0][k] <= in_entry.num[k];
        quo[0][k] <= '0;
        big[0][k] <= RW'(in_entry.num[k]) >= (RW'(in_entry.den2) << QW);
      end
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int BIT = QW - s;
    always_ff @(posedge clk) begin
      if (en) begin
        big[s] <= big[s-1];
        ng[s]  <= ng[s-1];
        zr[s]  <= zr[s-1];
        dv[s]  <= dv[s-1];
      end
    end
    for (genvar k = 0; k < NL; k++) begin : g_lane
      logic [RW-1:0] sub;
      logic          ge;
      assign sub = RW'(dv[s-1]) << BIT;
      assign ge  = RW'(rem[s-1][k]) >= sub;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s][k] <= ge ? NW'(RW'(rem[s-1][k]) - sub) : rem[s-1][k];
          quo[s][k] <= quo[s-1][k] | (ge ? (QW'(1) << BIT) : '0);
        end
      end
    end
  end

  // rounding is folded into the numerator; clamp and apply sign here
  for (genvar k = 0; k < NL; k++) begin : g_final
    logic [QW-1:0] nq;
    assign nq = -quo[QW][k];
    always_comb begin
      fval[k] = '0;
      fsat[k] = 1'b0;
      if (zr[QW]) begin
        fval[k] = '0;
      end else if (!ng[QW][k]) begin
        if (big[QW][k] || quo[QW][k] >= HALF) begin
          fval[k] = MAXV;
          fsat[k] = 1'b1;
        end else begin
          fval[k] = quo[QW][k][ELEM_WIDTH-1:0];
        end
      end else begin
        if (big[QW][k] || quo[QW][k] > HALF) begin
          fval[k] = MINV;
          fsat[k] = 1'b1;
        end else begin
          fval[k] = nq[ELEM_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NL; k++) res[k] <= fval[k];
      singular  <= zr[QW];
      saturated <= |fsat;
    end
  end

endmodule
`default_nettype wire

// ===== src/mat3_inverse_core.sv =====
// ----------------------------------------------------------------------------
// mat3_inverse_core: 3x3 fixed-point matrix inverse by adjugate / determinant
// path from request to response with no stalls: 7 front stages, the queue memory,
// 35 divider stages (operand load, one per quotient bit, result)
// throughput one request per cycle without stalls, set by fully pipelined divider lanes
// reset (synchronous, rst high) clears pipeline valid bits and queue pointers
// ----------------------------------------------------------------------------
`default_nettype none
module mat3_inverse_core (
  input  logic       clk,
  input  logic       rst,
  m3i_req_if.sink    req,
  m3i_resp_if.source resp
);
  import m3i_pkg::*;

  // matrix elements as an array, row-major
  elem_t    a [NL];
  elem_t    res [NL];

  // front to queue
  logic     f_valid;
  logic     f_ready;
  q_entry_t f_entry;

  // queue to divider
  logic     q_valid;
  logic     q_ready;
  q_entry_t q_entry;

  assign a[0] = req.a00;
  assign a[1] = req.a01;
  assign a[2] = req.a02;
  assign a[3] = req.a10;
  assign a[4] = req.a11;
  assign a[5] = req.a12;
  assign a[6] = req.a20;
  assign a[7] = req.a21;
  assign a[8] = req.a22;

  // front: minors, determinant, magnitudes, sign of each quotient
  m3i_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .a         (a),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_entry (f_entry)
  );

  // queue lets the front keep taking requests while the divider is stalled, until it fills
  m3i_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_entry  (f_entry),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_entry (q_entry)
  );

  // back: nine divider lanes, clamp, response register
  m3i_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_entry  (q_entry),
    .out_valid (resp.valid),
    .out_ready (resp.ready),
    .res       (res),
    .singular  (resp.singular),
    .saturated (resp.saturated)
  );

  assign resp.r00 = res[0];
  assign resp.r01 = res[1];
  assign resp.r02 = res[2];
  assign resp.r10 = res[3];
  assign resp.r11 = res[4];
  assign resp.r12 = res[5];
  assign resp.r20 = res[6];
  assign resp.r21 = res[7];
  assign resp.r22 = res[8];

`ifndef SYNTHESIS
  // a singular matrix gives an all-zero, unsaturated response
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    resp.valid && resp.singular |-> !resp.saturated && resp.r00 == '0 &&
      resp.r11 == '0 && resp.r22 == '0 && resp.r02 == '0 && resp.r20 == '0)
    else $error("singular response not cleared");

  // front output holds while the queue is full
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid && $stable(f_entry))
    else $error("front entry changed while queue full");

  // queue head is only removed by the divider taking it
  a_queue_pop: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid && $stable(q_entry))
    else $error("queue head lost without a pop");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_mat3_inverse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mat3_inverse_core: self-checking bench for the 3x3 matrix inverse core
// feeds matrices over the request channel, predicts each inverse with exact
// wide arithmetic (adjugate over determinant, rounded, saturated) and checks
// every response field in order, across phases of sender and receiver idling
// ----------------------------------------------------------------------------
module tb_mat3_inverse_core;
  import m3i_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;     // margin over the request-to-response latency

  typedef struct {
    elem_t m [NL];
  } matrix_t;

  typedef struct {
    elem_t r [NL];
    logic  singular;
    logic  saturated;
  } inverse_t;

  logic clk;
  logic rst;

  m3i_req_if  req ();
  m3i_resp_if resp ();

  mat3_inverse_core DUT (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  matrix_t  pending_mats [$];   // matrices waiting to be sent
  inverse_t expected_inv [$];   // predicted inverses, oldest first
  int       send_idle_pct;
  int       recv_stall_pct;
  int       errors;
  int       quiet_cycles;

  // rounded, saturated quotient of one adjugate entry by the determinant
  function automatic elem_t fx_quotient(logic signed [127:0] adj,
                                        logic signed [127:0] det,
                                        ref logic sat);
    logic [255:0] num;
    logic [255:0] den;
    logic [255:0] mag;
    logic [255:0] half;
    logic         neg;
    num  = adj[127] ? 256'(-adj) : 256'(adj);
    den  = det[127] ? 256'(-det) : 256'(det);
    neg  = adj[127] != det[127];
    half = 256'(1) << (ELEM_WIDTH - 1);
    // round to nearest, ties away from zero: (2|m|*2^2F + |d|) / 2|d|
    mag  = ((num << (2 * FRAC_BITS + 1)) + den) / (den << 1);
    if (!neg && mag >= half) begin
      sat = 1'b1;
      return elem_t'(half - 1);
    end
    if (neg && mag > half) begin
      sat = 1'b1;
      mag = half;
    end
    if (neg) mag = -mag;
    return elem_t'(mag[ELEM_WIDTH-1:0]);
  endfunction

  function automatic inverse_t invert_matrix(matrix_t a);
    inverse_t            res;
    logic signed [127:0] x [NL];
    logic signed [127:0] adj [NL];
    logic signed [127:0] det;
    logic                sat;
    for (int i = 0; i < NL; i++) x[i] = 128'(a.m[i]);
    // transposed cofactors, sign alternating across the flat index
    adj[0] =   x[4] * x[8] - x[5] * x[7];
    adj[1] = -(x[1] * x[8] - x[2] * x[7]);
    adj[2] =   x[1] * x[5] - x[2] * x[4];
    adj[3] = -(x[3] * x[8] - x[5] * x[6]);
    adj[4] =   x[0] * x[8] - x[2] * x[6];
    adj[5] = -(x[0] * x[5] - x[2] * x[3]);
    adj[6] =   x[3] * x[7] - x[4] * x[6];
    adj[7] = -(x[0] * x[7] - x[1] * x[6]);
    adj[8] =   x[0] * x[4] - x[1] * x[3];
    // expansion along the first row
    det = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
    sat = 1'b0;
    if (det == 0) begin
      for (int i = 0; i < NL; i++) res.r[i] = '0;
      res.singular  = 1'b1;
      res.saturated = 1'b0;
      return res;
    end
    for (int i = 0; i < NL; i++) res.r[i] = fx_quotient(adj[i], det, sat);
    res.singular  = 1'b0;
    res.saturated = sat;
    return res;
  endfunction

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($urandom);                              // full range
      1: return elem_t'($signed($urandom_range(2 * 262144)) - 262144); // +-4.0
      2: return elem_t'($signed($urandom_range(64)) - 32);      // tiny values
      default: return elem_t'(($signed($urandom_range(8)) - 4) <<< FRAC_BITS);
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t mt;
    int      kind;
    int      shape;
    kind  = $urandom_range(3);
    shape = $urandom_range(9);
    for (int i = 0; i < NL; i++) mt.m[i] = rand_elem(kind);
    if (shape == 0) begin
      // row 2 = row 0 + row 1: singular unless the sums wrap
      for (int j = 0; j < 3; j++) mt.m[6 + j] = mt.m[j] + mt.m[3 + j];
    end else if (shape == 1) begin
      // same, plus a one-lsb nudge: near singular, inverse saturates
      for (int j = 0; j < 3; j++) mt.m[6 + j] = mt.m[j] + mt.m[3 + j];
      mt.m[8] = mt.m[8] + 1;
    end else if (shape == 2) begin
      // diagonal
      for (int i = 0; i < NL; i++) if (i % 4 != 0) mt.m[i] = '0;
    end
    return mt;
  endfunction

  function automatic matrix_t diag_matrix(elem_t d0, elem_t d1, elem_t d2);
    matrix_t mt;
    for (int i = 0; i < NL; i++) mt.m[i] = '0;
    mt.m[0] = d0;
    mt.m[4] = d1;
    mt.m[8] = d2;
    return mt;
  endfunction

  function automatic matrix_t fill_matrix(elem_t v);
    matrix_t mt;
    for (int i = 0; i < NL; i++) mt.m[i] = v;
    return mt;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // request driver: next matrix goes out once the current one is taken
  always @(posedge clk) begin
    matrix_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (pending_mats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_mats.pop_front();
        req.a00 <= nxt.m[0]; req.a01 <= nxt.m[1]; req.a02 <= nxt.m[2];
        req.a10 <= nxt.m[3]; req.a11 <= nxt.m[4]; req.a12 <= nxt.m[5];
        req.a20 <= nxt.m[6]; req.a21 <= nxt.m[7]; req.a22 <= nxt.m[8];
        req.valid <= 1'b1;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // monitor: predicts on every accepted request, checks every response
  always @(posedge clk) begin
    matrix_t  taken;
    inverse_t exp_inv;
    elem_t    got [NL];
    if (rst) begin
      resp.ready   <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      resp.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (req.valid && req.ready) begin
        taken.m = '{req.a00, req.a01, req.a02, req.a10, req.a11, req.a12,
                    req.a20, req.a21, req.a22};
        expected_inv.push_back(invert_matrix(taken));
      end
      if (resp.valid && resp.ready) begin
        got = '{resp.r00, resp.r01, resp.r02, resp.r10, resp.r11, resp.r12,
                resp.r20, resp.r21, resp.r22};
        if (expected_inv.size() == 0) begin
          $display("%0t: response with none outstanding", $time);
          errors++;
        end else begin
          exp_inv = expected_inv.pop_front();
          for (int i = 0; i < NL; i++) begin
            if (got[i] !== exp_inv.r[i]) begin
              $display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                       exp_inv.r[i], got[i]);
              errors++;
            end
          end
          if (resp.singular !== exp_inv.singular) begin
            $display("%0t: singular expected %b actual %b", $time,
                     exp_inv.singular, resp.singular);
            errors++;
          end
          if (resp.saturated !== exp_inv.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     exp_inv.saturated, resp.saturated);
            errors++;
          end
        end
      end
      // watchdog on handshake activity
      if ((req.valid && req.ready) || (resp.valid && resp.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus and phase control
  initial begin
    matrix_t mt;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst            = 1'b1;
    req.valid      = 1'b0;
    resp.ready     = 1'b0;
    req.a00 = '0; req.a01 = '0; req.a02 = '0;
    req.a10 = '0; req.a11 = '0; req.a12 = '0;
    req.a20 = '0; req.a21 = '0; req.a22 = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed matrices
    pending_mats.push_back(diag_matrix(32'sh10000, 32'sh10000, 32'sh10000));
    pending_mats.push_back(fill_matrix('0));                 // all zero: singular
    pending_mats.push_back(fill_matrix(32'sh7fffffff));      // rank one: singular
    pending_mats.push_back(fill_matrix(32'sh80000000));
    pending_mats.push_back(diag_matrix(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    pending_mats.push_back(diag_matrix(32'sh80000000, 32'sh80000000, 32'sh80000000));
    pending_mats.push_back(diag_matrix(32'sh1, 32'sh1, 32'sh1)); // huge inverse
    pending_mats.push_back(diag_matrix(-32'sh1, -32'sh1, -32'sh1));
    pending_mats.push_back(diag_matrix(32'sh8000, -32'sh8000, 32'sh10000)); // 2, -2, 1
    pending_mats.push_back(diag_matrix(32'sh30000, 32'sh30000, 32'sh30000)); // 1/3 rounding
    pending_mats.push_back(diag_matrix(32'sh20000, 32'sh20000, 32'sh20000));
    pending_mats.push_back(diag_matrix(32'sh1, 32'sh2, -32'sh1)); // mixed clamp sides
    pending_mats.push_back(diag_matrix(32'sh2, 32'sh2, 32'sh2)); // exact positive max+1
    mt.m = '{32'sh0, 32'sh10000, 32'sh0, 32'sh0, 32'sh0, 32'sh10000,
             32'sh10000, 32'sh0, 32'sh0};                    // permutation
    pending_mats.push_back(mt);
    mt.m = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000,
             32'sh60000, 32'sh70000, 32'sh80000, 32'sh90000}; // singular 1..9
    pending_mats.push_back(mt);
    mt.m = '{32'sh20000, -32'sh10000, 32'sh0, -32'sh10000, 32'sh20000,
             -32'sh10000, 32'sh0, -32'sh10000, 32'sh20000};   // tridiagonal
    pending_mats.push_back(mt);
    mt.m = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
             32'sh7fffffff, 32'sh0, 32'sh1, 32'sh0, 32'sh80000000};
    pending_mats.push_back(mt);
    mt.m = '{32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
             32'shf0f0f0f0, 32'sh12345678, 32'sh87654321, 32'sh1, 32'sh7ffffffe};
    pending_mats.push_back(mt);
    while (pending_mats.size() > 0 || req.valid || expected_inv.size() > 0)
      @(posedge clk);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 13 : 0;
      recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 13 : 0;
      for (int n = 0; n < 150; n++) pending_mats.push_back(random_matrix());
      // stimulus waits here until the whole phase has drained
      while (pending_mats.size() > 0 || req.valid || expected_inv.size() > 0)
        @(posedge clk);
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_inv.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/m3i_pkg.sv
src/m3i_req_if.sv
src/m3i_resp_if.sv
src/m3i_front.sv
src/m3i_queue.sv
src/m3i_back.sv
src/mat3_inverse_core.sv
bench/tb_mat3_inverse_core.sv
